// File: rtl/epd_pkg.sv
`timescale 1ns / 1ps

package epd_pkg;

	// Delay line geometry
	localparam int LINE_LEN = 16;
	localparam int AW       = 4;
	localparam int TEST_POS = 15;

	// Field widths
	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 16;
	localparam int ENV_W    = 32;
	localparam int AGE_W    = 17;
	localparam int PROD_W   = ENV_W + GAIN_W;

	localparam int PEAK_WINDOW_DEF = 16;

	// Register reset values
	localparam logic [GAIN_W-1:0] DECAY_RST  = 16'd6554;
	localparam logic [GAIN_W-1:0] THRESH_RST = 16'd6554;
	localparam logic [GAIN_W-1:0] RANGE_RST  = 16'd655;

	// Envelope reset values, Q16.16
	localparam logic signed [ENV_W-1:0] MAX_ENV_RST = 32'sh8000_0000;
	localparam logic signed [ENV_W-1:0] MIN_ENV_RST = 32'sh7FFF_0000;

	localparam logic [AGE_W-1:0] AGE_SAT = '1;

	// Register indexes
	typedef enum logic [1:0] {
		REG_DECAY  = 2'd0,
		REG_THRESH = 2'd1,
		REG_RANGE  = 2'd2
	} cfg_reg_e;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
	} sample_item_t;

	typedef struct packed {
		logic                       peak_found;
		logic [3:0]                 peak_offset;
		logic [15:0]                peak_interval;
		logic signed [SAMPLE_W-1:0] peak_amplitude;
		logic [15:0]                dynamic_range;
	} result_item_t;

	typedef struct packed {
		logic [1:0]        reg_index;
		logic [GAIN_W-1:0] wdata;
	} cfg_item_t;

	typedef struct packed {
		logic [GAIN_W-1:0] decay;
		logic [GAIN_W-1:0] thresh;
		logic [GAIN_W-1:0] range;
	} cfg_regs_t;

	// Window statistics gathered by one sweep of the line
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] wmax;
		logic signed [SAMPLE_W-1:0] wmin;
		logic signed [SAMPLE_W-1:0] best;
		logic [AW-1:0]              best_age;
		logic signed [SAMPLE_W-1:0] test;
	} scan_res_t;

endpackage

// File: rtl/epd_chan_if.sv
`timescale 1ns / 1ps

interface epd_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/epd_line_mem.sv
`timescale 1ns / 1ps

module epd_line_mem (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                we,
	input  logic signed [epd_pkg::SAMPLE_W-1:0] wdata,
	input  logic                                re,
	input  logic [epd_pkg::AW-1:0]              rd_age,
	output logic signed [epd_pkg::SAMPLE_W-1:0] rdata
);
	import epd_pkg::*;

	logic [SAMPLE_W-1:0] mem_q [LINE_LEN];
	logic [AW-1:0]       head_q;
	logic [LINE_LEN-1:0] vld_q;
	logic [SAMPLE_W-1:0] rdata_s1;
	logic                rvld_s1;
	logic [AW-1:0]       rd_addr;

	// Age 0 sits just below the write pointer
	assign rd_addr = head_q - AW'(1) - rd_age;

	// Storage array, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[head_q] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem_q[rd_addr];
		end
	end

	// Write pointer and per-entry valid bits; unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (we) begin
				head_q         <= head_q + AW'(1);
				vld_q[head_q]  <= 1'b1;
			end
			if (re) begin
				rvld_s1 <= vld_q[rd_addr];
			end
		end
	end

	assign rdata = rvld_s1 ? $signed(rdata_s1) : '0;

endmodule

// File: rtl/epd_scan.sv
`timescale 1ns / 1ps

module epd_scan #(
	parameter int WIN = epd_pkg::PEAK_WINDOW_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic [epd_pkg::AW-1:0]              pos,
	input  logic signed [epd_pkg::SAMPLE_W-1:0] rdata,
	output epd_pkg::scan_res_t                  res
);
	import epd_pkg::*;

	logic          en_s1;
	logic [AW-1:0] pos_s1;
	scan_res_t     res_q;
	logic          first;
	logic          in_win;
	logic [AW-1:0] age;

	// Align read position with the registered memory data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1  <= 1'b0;
			pos_s1 <= '0;
		end else begin
			en_s1  <= en;
			pos_s1 <= pos;
		end
	end

	// Oldest entry comes first; it is also the tested sample
	assign first  = (pos_s1 == '0);
	assign age    = AW'(TEST_POS) - pos_s1;
	assign in_win = ({1'b0, pos_s1} < (AW+1)'(WIN));

	// Running max/min and earliest argmax of the peak window
	always_ff @(posedge clk) begin
		if (en_s1) begin
			if (first) begin
				res_q.wmax     <= rdata;
				res_q.wmin     <= rdata;
				res_q.best     <= rdata;
				res_q.best_age <= age;
				res_q.test     <= rdata;
			end else begin
				if (rdata > res_q.wmax) begin
					res_q.wmax <= rdata;
				end
				if (rdata < res_q.wmin) begin
					res_q.wmin <= rdata;
				end
				// strict compare keeps the oldest of equal maxima
				if (in_win && (rdata > res_q.best)) begin
					res_q.best     <= rdata;
					res_q.best_age <= age;
				end
			end
		end
	end

	assign res = res_q;

endmodule

// File: rtl/epd_env_unit.sv
`timescale 1ns / 1ps

module epd_env_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  epd_pkg::cfg_regs_t cfg,
	input  epd_pkg::scan_res_t res,
	output logic               done,
	output logic               above,
	output logic [15:0]        dyn_range
);
	import epd_pkg::*;

	typedef enum logic [8:0] {
		EV_IDLE = 9'b000000001,
		EV_MULM = 9'b000000010,
		EV_MULN = 9'b000000100,
		EV_UPDN = 9'b000001000,
		EV_SPRD = 9'b000010000,
		EV_MULT = 9'b000100000,
		EV_CMP  = 9'b001000000,
		EV_MULR = 9'b010000000,
		EV_UPDR = 9'b100000000
	} ev_state_t;

	ev_state_t               state_q;
	logic signed [ENV_W-1:0] max_q;
	logic signed [ENV_W-1:0] min_q;
	logic [ENV_W-1:0]        rf_q;
	logic [ENV_W-1:0]        spread_q;
	logic [ENV_W-1:0]        rmag_q;
	logic                    rneg_q;
	logic                    above_q;
	logic [PROD_W-1:0]       prod_q;

	logic signed [ENV_W-1:0] mq;
	logic signed [ENV_W-1:0] nq;
	logic                    jump_m;
	logic                    jump_n;
	logic [ENV_W-1:0]        diff_m;
	logic [ENV_W-1:0]        diff_n;
	logic [ENV_W-1:0]        amt;
	logic signed [ENV_W:0]   sdiff;
	logic [ENV_W:0]          sdiff_neg;
	logic signed [ENV_W+1:0] thr;
	logic signed [ENV_W+1:0] vq;
	logic [ENV_W:0]          rdiff;
	logic [ENV_W:0]          rdiff_neg;
	logic [ENV_W-1:0]        mul_a;
	logic [GAIN_W-1:0]       mul_b;

	// Window extremes in Q16.16
	assign mq     = {res.wmax, 16'h0000};
	assign nq     = {res.wmin, 16'h0000};
	assign jump_m = (mq > max_q);
	assign jump_n = (nq < min_q);
	assign diff_m = max_q - mq;
	assign diff_n = nq - min_q;
	assign amt    = prod_q[PROD_W-1:GAIN_W];

	// Envelope spread magnitude
	assign sdiff     = {max_q[ENV_W-1], max_q} - {min_q[ENV_W-1], min_q};
	assign sdiff_neg = -sdiff;

	// Threshold compare in 34 bits
	assign thr = {{2{max_q[ENV_W-1]}}, max_q} - {2'b00, amt};
	assign vq  = {{2{res.test[SAMPLE_W-1]}}, res.test, 16'h0000};

	// Range filter error
	assign rdiff     = {1'b0, spread_q} - {1'b0, rf_q};
	assign rdiff_neg = -rdiff;

	// Shared multiplier operand select
	always_comb begin
		case (state_q)
			EV_MULM: begin
				mul_a = diff_m;
				mul_b = cfg.decay;
			end
			EV_MULN: begin
				mul_a = diff_n;
				mul_b = cfg.decay;
			end
			EV_MULT: begin
				mul_a = spread_q;
				mul_b = cfg.thresh;
			end
			EV_MULR: begin
				mul_a = rmag_q;
				mul_b = cfg.range;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// Sequencer and state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= EV_IDLE;
			max_q    <= MAX_ENV_RST;
			min_q    <= MIN_ENV_RST;
			rf_q     <= '0;
			spread_q <= '0;
			rmag_q   <= '0;
			rneg_q   <= 1'b0;
			above_q  <= 1'b0;
		end else begin
			case (state_q)
				EV_IDLE: begin
					if (start) begin
						state_q <= EV_MULM;
					end
				end
				EV_MULM: begin
					state_q <= EV_MULN;
				end
				EV_MULN: begin
					max_q   <= jump_m ? mq : max_q - amt;
					state_q <= EV_UPDN;
				end
				EV_UPDN: begin
					min_q   <= jump_n ? nq : min_q + amt;
					state_q <= EV_SPRD;
				end
				EV_SPRD: begin
					spread_q <= sdiff[ENV_W] ? sdiff_neg[ENV_W-1:0] : sdiff[ENV_W-1:0];
					state_q  <= EV_MULT;
				end
				EV_MULT: begin
					state_q <= EV_CMP;
				end
				EV_CMP: begin
					above_q <= (vq > thr);
					rneg_q  <= rdiff[ENV_W];
					rmag_q  <= rdiff[ENV_W] ? rdiff_neg[ENV_W-1:0] : rdiff[ENV_W-1:0];
					state_q <= EV_MULR;
				end
				EV_MULR: begin
					state_q <= EV_UPDR;
				end
				EV_UPDR: begin
					rf_q    <= rneg_q ? rf_q - amt : rf_q + amt;
					state_q <= EV_IDLE;
				end
				default: begin
					state_q <= EV_IDLE;
				end
			endcase
		end
	end

	assign done      = (state_q == EV_UPDR);
	assign above     = above_q;
	assign dyn_range = rf_q[ENV_W-1:16];

endmodule

// File: rtl/envelope_peak_detector_core.sv
`timescale 1ns / 1ps

// Channel     Dir  Payload                                           Transfer
// sample_ch   in   sample                                            valid & ready
// result_ch   out  peak_found, peak_offset, peak_interval,           valid & ready
//                  peak_amplitude, dynamic_range
// cfg_ch      in   reg_index, wdata                                  valid & ready
//
// One sample runs, transfer to transfer, through the transfer, 16 reads of the line
// memory through its single read port, a drain of the read pipe, eight steps on one
// shared 32x16 multiplier, and a load of the output register.
// A finished result waits in the output register while the next sample runs; the
// block stalls only if that register is still full when the next result is ready.
// Reset clears FSM state, range filter, peak age, line valid bits; sets envelopes.

module envelope_peak_detector_core #(
	parameter int PEAK_WINDOW = epd_pkg::PEAK_WINDOW_DEF
) (
	input logic         clk,
	input logic         arst_n,
	epd_chan_if.sink    sample_ch,
	epd_chan_if.source  result_ch,
	epd_chan_if.sink    cfg_ch
);
	import epd_pkg::*;

	localparam int WIN = (PEAK_WINDOW > LINE_LEN) ? LINE_LEN : PEAK_WINDOW;
	localparam logic [AGE_W-1:0] REFRACT = AGE_W'(TEST_POS + WIN);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SWEEP = 5'b00010,
		ST_LAST  = 5'b00100,
		ST_CALC  = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t           state_q;
	logic [AW-1:0]    cnt_q;
	logic [AGE_W-1:0] age_q;
	cfg_regs_t        cfg_q;
	result_item_t     result_q;
	logic             ovld_q;

	logic                       in_xfer;
	logic                       rd_en;
	logic [AW-1:0]              rd_age;
	logic signed [SAMPLE_W-1:0] rdata;
	scan_res_t                  scan_res;
	logic                       env_done;
	logic                       above;
	logic [15:0]                dyn_range;
	logic                       found;
	logic [AGE_W-1:0]           ivl;
	logic                       load_out;

	// Configuration registers
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decay  <= DECAY_RST;
			cfg_q.thresh <= THRESH_RST;
			cfg_q.range  <= RANGE_RST;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.data.reg_index)
				REG_DECAY:  cfg_q.decay  <= cfg_ch.data.wdata;
				REG_THRESH: cfg_q.thresh <= cfg_ch.data.wdata;
				REG_RANGE:  cfg_q.range  <= cfg_ch.data.wdata;
				default: ;
			endcase
		end
	end

	// Input handshake and sweep addressing, oldest entry first
	assign sample_ch.ready = (state_q == ST_IDLE);
	assign in_xfer         = sample_ch.valid && sample_ch.ready;
	assign rd_en           = (state_q == ST_SWEEP);
	assign rd_age          = AW'(TEST_POS) - cnt_q;

	epd_line_mem u_line_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (in_xfer),
		.wdata  (sample_ch.data.sample),
		.re     (rd_en),
		.rd_age (rd_age),
		.rdata  (rdata)
	);

	epd_scan #(
		.WIN (WIN)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (rd_en),
		.pos    (cnt_q),
		.rdata  (rdata),
		.res    (scan_res)
	);

	epd_env_unit u_env (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (state_q == ST_LAST),
		.cfg       (cfg_q),
		.res       (scan_res),
		.done      (env_done),
		.above     (above),
		.dyn_range (dyn_range)
	);

	// Peak decision and interval
	assign found    = above && (age_q >= REFRACT);
	assign ivl      = age_q - AGE_W'(scan_res.best_age);
	assign load_out = (state_q == ST_OUT) && (!ovld_q || result_ch.ready);

	// Control sequencer and peak age
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			age_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						cnt_q   <= '0;
						state_q <= ST_SWEEP;
						if (age_q != AGE_SAT) begin
							age_q <= age_q + AGE_W'(1);
						end
					end
				end
				ST_SWEEP: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == AW'(TEST_POS)) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (env_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
						if (found) begin
							age_q <= AGE_W'(scan_res.best_age);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (load_out) begin
			ovld_q <= 1'b1;
		end else if (result_ch.ready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q.peak_found     <= found;
			result_q.peak_offset    <= found ? scan_res.best_age : '0;
			result_q.peak_interval  <= !found ? '0 :
			                           (ivl[AGE_W-1] ? 16'hFFFF : ivl[15:0]);
			result_q.peak_amplitude <= found ? scan_res.best : '0;
			result_q.dynamic_range  <= dyn_range;
		end
	end

	assign result_ch.valid = ovld_q;
	assign result_ch.data  = result_q;

endmodule

// File: rtl/epd_checker.sv
`timescale 1ns / 1ps

module epd_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input epd_pkg::result_item_t out_data
);
	import epd_pkg::*;

	// A stalled result holds its payload
	ast_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("result changed while stalled");

	// One sample at a time: busy right after a transfer
	ast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while a sample is in work");

	// No peak means the peak fields are cleared
	ast_no_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.peak_found) |->
		(out_data.peak_offset == '0 && out_data.peak_interval == '0 &&
		 out_data.peak_amplitude == '0))
		else $error("peak fields set without a peak");

	// Refractory distance keeps a peak interval above zero
	ast_interval: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.peak_found) |-> (out_data.peak_interval != '0))
		else $error("peak reported with zero interval");

endmodule

bind envelope_peak_detector_core epd_checker u_epd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample_ch.valid),
	.in_ready  (sample_ch.ready),
	.out_valid (result_ch.valid),
	.out_ready (result_ch.ready),
	.out_data  (result_ch.data)
);

// File: dv/envelope_peak_detector_core_tb.sv
`timescale 1ns / 1ps

module envelope_peak_detector_core_tb;
	import epd_pkg::*;

	localparam int PEAK_WIN     = PEAK_WINDOW_DEF;
	localparam int ITEMS_TOTAL  = 700;
	localparam int QUIET_FROM   = 600;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;

	// Index past the last register; writes there must be ignored
	localparam logic [1:0] REG_UNUSED = 2'd3;

	localparam result_item_t QUIET = '0;

	typedef enum bit {ROW_SAMPLE, ROW_CFG} row_kind_e;

	typedef struct packed {
		row_kind_e    kind;
		logic [1:0]   idx;
		logic [15:0]  value;
		bit           typed;
		result_item_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	epd_chan_if #(.payload_t(sample_item_t)) sample_ch ();
	epd_chan_if #(.payload_t(result_item_t)) result_ch ();
	epd_chan_if #(.payload_t(cfg_item_t))    cfg_ch ();

	envelope_peak_detector_core #(.PEAK_WINDOW(PEAK_WIN)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg_ch    (cfg_ch)
	);

	always #1 clk = ~clk;

	// Tracker state: delay line, envelopes (Q16.16), range filter, peak age, gains
	logic signed [15:0] hist [LINE_LEN];
	longint env_hi, env_lo, range_acc;
	int     peak_age;
	longint gain_decay, gain_thresh, gain_range;

	result_item_t pending_reports [$];
	result_item_t oldest_report;
	int  errors = 0;
	int  items_sent = 0;
	int  cycle_cnt;
	bit  idle_on = 1'b1;

	// Directed rows; reg_index is a don't-care on sample rows
	dir_row_t dir_table [24] = '{
		'{ROW_SAMPLE, REG_DECAY,  16'h0000, 1'b1, QUIET},
		'{ROW_SAMPLE, REG_DECAY,  16'h7FFF, 1'b1, '{1'b0, 4'd0, 16'd0, 16'sd0, 16'd327}},
		'{ROW_SAMPLE, REG_DECAY,  16'h8000, 1'b0, QUIET},
		'{ROW_SAMPLE, REG_DECAY,  16'hFFFF, 1'b0, QUIET},
		'{ROW_SAMPLE, REG_DECAY,  16'h0001, 1'b0, QUIET},
		'{ROW_SAMPLE, REG_DECAY,  16'h5555, 1'b0, QUIET},
		'{ROW_SAMPLE, REG_DECAY,  16'hAAAA, 1'b0, QUIET},
		'{ROW_CFG,    REG_UNUSED, 16'hFFFF, 1'b0, QUIET},
		'{ROW_CFG,    REG_DECAY,  16'h0000, 1'b0, QUIET},
		'{ROW_CFG,    REG_THRESH, 16'hFFFF, 1'b0, QUIET},
		'{ROW_CFG,    REG_RANGE,  16'hFFFF, 1'b0, QUIET},
		'{ROW_SAMPLE, REG_DECAY,  16'h0100, 1'b0, QUIET},
		'{ROW_SAMPLE, REG_DECAY,  16'h0100, 1'b0, QUIET},
		'{ROW_SAMPLE, REG_DECAY,  16'hFF00, 1'b0, QUIET},
		'{ROW_SAMPLE, REG_DECAY,  16'h7FFF, 1'b0, QUIET},
		'{ROW_CFG,    REG_DECAY,  16'hFFFF, 1'b0, QUIET},
		'{ROW_CFG,    REG_THRESH, 16'h0000, 1'b0, QUIET},
		'{ROW_CFG,    REG_RANGE,  16'h0000, 1'b0, QUIET},
		'{ROW_SAMPLE, REG_DECAY,  16'h0000, 1'b0, QUIET},
		'{ROW_SAMPLE, REG_DECAY,  16'h8000, 1'b0, QUIET},
		'{ROW_SAMPLE, REG_DECAY,  16'h7FFF, 1'b0, QUIET},
		'{ROW_CFG,    REG_DECAY,  DECAY_RST,  1'b0, QUIET},
		'{ROW_CFG,    REG_THRESH, THRESH_RST, 1'b0, QUIET},
		'{ROW_CFG,    REG_RANGE,  RANGE_RST,  1'b0, QUIET}
	};

	// Advance the tracker by one sample and return the report it yields
	function automatic result_item_t next_peak_report(input logic signed [15:0] s);
		result_item_t       r;
		longint             wmax, wmin, hi_q, lo_q, spread, thr, diff, test_q;
		logic signed [15:0] best;
		int                 k, best_k, win, offset, interval;
		r = '0;
		for (k = LINE_LEN - 1; k > 0; k--)
			hist[k] = hist[k-1];
		hist[0] = s;
		if (peak_age < AGE_SAT)
			peak_age++;

		// line extremes
		wmax = longint'(hist[0]);
		wmin = longint'(hist[0]);
		for (k = 1; k < LINE_LEN; k++) begin
			if (hist[k] > wmax) wmax = longint'(hist[k]);
			if (hist[k] < wmin) wmin = longint'(hist[k]);
		end

		// envelopes jump to new extremes, otherwise decay toward the line
		hi_q = wmax * 65536;
		if (hi_q > env_hi)
			env_hi = hi_q;
		else
			env_hi = env_hi - (((env_hi - hi_q) * gain_decay) >> 16);
		lo_q = wmin * 65536;
		if (lo_q < env_lo)
			env_lo = lo_q;
		else
			env_lo = env_lo + (((lo_q - env_lo) * gain_decay) >> 16);

		spread = env_hi - env_lo;
		if (spread < 0) spread = -spread;
		thr = env_hi - ((spread * gain_thresh) >> 16);

		// range filter step, truncated toward zero
		diff = spread - range_acc;
		if (diff >= 0)
			range_acc = range_acc + ((diff * gain_range) >> 16);
		else
			range_acc = range_acc - (((-diff) * gain_range) >> 16);

		// threshold crossing at the oldest position, outside refractory distance
		test_q = longint'(hist[TEST_POS]) * 65536;
		if (test_q > thr && peak_age >= TEST_POS + PEAK_WIN) begin
			win = (PEAK_WIN > LINE_LEN) ? LINE_LEN : PEAK_WIN;
			best_k = 0;
			best = hist[TEST_POS];
			// strict compare keeps the oldest of equal maxima
			for (k = 1; k < win; k++) begin
				if (hist[TEST_POS-k] > best) begin
					best = hist[TEST_POS-k];
					best_k = k;
				end
			end
			offset = TEST_POS - best_k;
			interval = peak_age - offset;
			r.peak_found = 1'b1;
			r.peak_offset = offset[3:0];
			r.peak_interval = (interval > 65535) ? 16'hFFFF : interval[15:0];
			r.peak_amplitude = best;
			peak_age = offset;
		end
		r.dynamic_range = range_acc[31:16];
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// Sample transfer; returns at the next falling edge with valid still high
	task automatic send_sample(input int v, input bit typed, input result_item_t want);
		sample_item_t item;
		result_item_t predicted;
		if (v > 32767)
			v = 32767;
		else if (v < -32768)
			v = -32768;
		item.sample = v[15:0];
		if (idle_on && $urandom_range(0, 2) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.data <= item;
		do @(posedge clk); while (!sample_ch.ready);
		predicted = next_peak_report(item.sample);
		pending_reports.push_back(typed ? want : predicted);
		items_sent++;
		@(negedge clk);
	endtask

	// Stop sending and wait until every report has come back
	task automatic quiesce();
		if (sample_ch.valid) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		while (pending_reports.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_gain(input logic [1:0] idx, input logic [15:0] val);
		cfg_item_t c;
		c.reg_index = idx;
		c.wdata = val;
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= c;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_DECAY:  gain_decay = longint'(val);
			REG_THRESH: gain_thresh = longint'(val);
			REG_RANGE:  gain_range = longint'(val);
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// One random stretch: pulse trains mostly, plus noise, flat runs, gain changes
	task automatic run_segment();
		int         kind, base, peak, period, width, pulses, noise, jit, len, v, nwr, p, i;
		bit         flip;
		logic [1:0] idx;
		logic [15:0] val;
		kind = $urandom_range(0, 11);
		if (items_sent < QUIET_FROM)
			idle_on = ($urandom_range(0, 2) != 0);
		else
			idle_on = 1'b0;

		if (kind <= 6) begin
			// pulse train; plateaus wider than one sample give tied maxima
			base = int'($urandom_range(0, 4000)) - 2000;
			peak = ($urandom_range(0, 3) == 0) ? 32767 : base + int'($urandom_range(300, 30000));
			period = $urandom_range(6, 48);
			width = $urandom_range(1, 3);
			pulses = $urandom_range(2, 5);
			noise = $urandom_range(0, 200);
			flip = ($urandom_range(0, 3) == 0);
			for (p = 0; p < pulses && items_sent < ITEMS_TOTAL; p++) begin
				jit = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 500));
				for (i = 0; i < period && items_sent < ITEMS_TOTAL; i++) begin
					if (i < width)
						v = peak - jit;
					else
						v = base + int'($urandom_range(0, 2 * noise)) - noise;
					send_sample(flip ? -v : v, 1'b0, QUIET);
				end
			end
		end else if (kind <= 8) begin
			// full-scale noise
			len = $urandom_range(10, 30);
			for (i = 0; i < len && items_sent < ITEMS_TOTAL; i++)
				send_sample(int'($urandom_range(0, 65535)) - 32768, 1'b0, QUIET);
		end else if (kind == 9) begin
			// flat run lets the envelopes settle
			v = int'($urandom_range(0, 65535)) - 32768;
			len = $urandom_range(10, 40);
			for (i = 0; i < len && items_sent < ITEMS_TOTAL; i++)
				send_sample(v, 1'b0, QUIET);
		end else if (kind == 10) begin
			quiesce();
			nwr = $urandom_range(1, 3);
			for (i = 0; i < nwr; i++) begin
				idx = 2'($urandom_range(REG_DECAY, REG_UNUSED));
				case ($urandom_range(0, 3))
					0: val = 16'h0000;
					1: val = 16'hFFFF;
					default: val = 16'($urandom_range(0, 65535));
				endcase
				write_gain(idx, val);
			end
		end else begin
			// sender holds off until the block has drained
			quiesce();
		end
	endtask

	// Result channel back-pressure
	initial begin
		result_ch.ready <= 1'b1;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 3) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
		end
	end

	// Compare each result transfer with the oldest pending report
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_reports.size() == 0) begin
				$display("%t unexpected result: expected none, actual %p", $time,
					result_ch.data);
				errors++;
			end else begin
				oldest_report = pending_reports.pop_front();
				check_field("peak_found", 16'(oldest_report.peak_found),
					16'(result_ch.data.peak_found));
				check_field("peak_offset", 16'(oldest_report.peak_offset),
					16'(result_ch.data.peak_offset));
				check_field("peak_interval", oldest_report.peak_interval,
					result_ch.data.peak_interval);
				check_field("peak_amplitude", oldest_report.peak_amplitude,
					result_ch.data.peak_amplitude);
				check_field("dynamic_range", oldest_report.dynamic_range,
					result_ch.data.dynamic_range);
			end
		end
	end

	// Run limit
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("%t timeout after %0d cycles, %0d reports pending", $time, cycle_cnt,
			pending_reports.size());
		$display("envelope_peak_detector_core_tb: FAIL");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		sample_ch.valid <= 1'b0;
		sample_ch.data <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;

		// tracker reset
		foreach (hist[k])
			hist[k] = '0;
		env_hi = longint'(MAX_ENV_RST);
		env_lo = longint'(MIN_ENV_RST);
		range_acc = 0;
		peak_age = 0;
		gain_decay = longint'(DECAY_RST);
		gain_thresh = longint'(THRESH_RST);
		gain_range = longint'(RANGE_RST);

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed rows
		foreach (dir_table[i]) begin
			if (dir_table[i].kind == ROW_CFG) begin
				quiesce();
				write_gain(dir_table[i].idx, dir_table[i].value);
			end else begin
				send_sample(int'($signed(dir_table[i].value)), dir_table[i].typed,
					dir_table[i].want);
			end
		end

		while (items_sent < ITEMS_TOTAL)
			run_segment();

		quiesce();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("envelope_peak_detector_core_tb: PASS");
		else
			$display("envelope_peak_detector_core_tb: FAIL");
		$finish;
	end

endmodule
